>>> hdl/kcdl_pkg.sv
// Shared types and constants for the key click / double / long-press detector.
package kcdl_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam int IDX_WIDTH   = 2;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
  typedef logic [CMP_WIDTH-1:0]   cmp_t;

  typedef enum logic [1:0] {
    PH_UP             = 2'd0,
    PH_PRESS_BOUNCE   = 2'd1,
    PH_DOWN           = 2'd2,
    PH_RELEASE_BOUNCE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  localparam logic [IDX_WIDTH-1:0] REG_SCAN_PERIOD = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_DOUBLE_GAP  = 2'd2;

  localparam cfg_word_t SCAN_PERIOD_RESET = 16'd10;
  localparam cfg_word_t LONG_PRESS_RESET  = 16'd2000;
  localparam cfg_word_t DOUBLE_GAP_RESET  = 16'd200;

  localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

  function automatic timer_t sat_inc(input timer_t v);
    sat_inc = (v == TIMER_MAX) ? TIMER_MAX : v + timer_t'(1);
  endfunction

endpackage

>>> hdl/key_click_double_long_detector_core.sv
// Key click, double-click and long-press detector, top level.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[0] key_level
//  m_*     | out | m_tvalid/m_tready  | m_tdata[1:0] key_event
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// One tick item per cycle; each accepted item gives one event item.
// Timers, phase, pending click and the output register all update at the
// accepting edge; the event item is offered from the next cycle on.
// The input side stays ready while the output register is empty or drained
// in the same cycle. rst is synchronous and clears all control state.
module key_click_double_long_detector_core
  import kcdl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] key_level, [7:1] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [1:0] key_event, [7:2] zero
  input  logic                 cfg_we,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  cfg_word_t scan_period;
  cfg_word_t long_press_ticks;
  cfg_word_t double_gap_ticks;

  phase_t key_phase, key_phase_next;
  timer_t scan_count, scan_count_next;
  timer_t hold_count, hold_count_next;
  timer_t gap_count, gap_count_next;
  logic   click_pending, click_pending_next;
  event_t key_event_next;
  logic [1:0] key_event;

  logic   s_fire;
  logic   released;
  timer_t scan_inc, hold_inc, gap_inc;
  logic   scan_run;
  logic   long_hit;
  logic   gap_hit;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign released = s_tdata[0];

  assign scan_inc = sat_inc(scan_count);
  assign hold_inc = sat_inc(hold_count);
  assign gap_inc  = sat_inc(gap_count);

  assign scan_run = cmp_t'(scan_inc) >= cmp_t'(scan_period);
  assign long_hit = cmp_t'(hold_inc) >= cmp_t'(long_press_ticks);
  assign gap_hit  = cmp_t'(gap_inc) >= cmp_t'(double_gap_ticks);

  always_comb begin
    key_phase_next = key_phase;
    if (scan_run) begin
      unique case (key_phase)
        PH_UP: begin
          if (!released) key_phase_next = PH_PRESS_BOUNCE;
        end
        PH_PRESS_BOUNCE: begin
          key_phase_next = released ? PH_UP : PH_DOWN;
        end
        PH_DOWN: begin
          if (released || long_hit) key_phase_next = PH_RELEASE_BOUNCE;
        end
        PH_RELEASE_BOUNCE: begin
          if (released) key_phase_next = PH_UP;
        end
        default: key_phase_next = PH_UP;
      endcase
    end
  end

  always_comb begin
    key_event_next     = EV_NONE;
    click_pending_next = click_pending;
    scan_count_next    = scan_run ? '0 : scan_inc;
    hold_count_next    = hold_inc;
    gap_count_next     = gap_inc;
    if (scan_run) begin
      unique case (key_phase)
        PH_UP: begin
          if (released && click_pending && gap_hit) begin
            key_event_next     = EV_SINGLE;
            click_pending_next = 1'b0;
          end
        end
        PH_PRESS_BOUNCE: begin
          if (!released) hold_count_next = '0;
        end
        PH_DOWN: begin
          if (!released) begin
            if (long_hit) begin
              key_event_next     = EV_LONG;
              click_pending_next = 1'b0;
            end
          end else if (click_pending) begin
            key_event_next     = EV_DOUBLE;
            click_pending_next = 1'b0;
          end else begin
            click_pending_next = 1'b1;
            gap_count_next     = '0;
          end
        end
        PH_RELEASE_BOUNCE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period      <= SCAN_PERIOD_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
      double_gap_ticks <= DOUBLE_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCAN_PERIOD: scan_period      <= cfg_data;
        REG_LONG_PRESS:  long_press_ticks <= cfg_data;
        REG_DOUBLE_GAP:  double_gap_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_phase     <= PH_UP;
      scan_count    <= '0;
      hold_count    <= '0;
      gap_count     <= '0;
      click_pending <= 1'b0;
    end else if (s_fire) begin
      key_phase     <= key_phase_next;
      scan_count    <= scan_count_next;
      hold_count    <= hold_count_next;
      gap_count     <= gap_count_next;
      click_pending <= click_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      key_event <= key_event_next;
    end
  end

  assign m_tdata = {6'd0, key_event};

  a_long_ends_down: assert property (@(posedge clk) disable iff (rst)
    s_fire && key_event_next == EV_LONG |=> key_phase == PH_RELEASE_BOUNCE && !click_pending)
    else $error("long press did not leave the down phase with no click pending");

  a_double_clears: assert property (@(posedge clk) disable iff (rst)
    s_fire && key_event_next == EV_DOUBLE |=> !click_pending && m_tvalid)
    else $error("double click left a click pending or no item out");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_fire |=> $stable(scan_count) && $stable(hold_count) && $stable(gap_count))
    else $error("timers moved without an accepted item");

  a_single_from_up: assert property (@(posedge clk) disable iff (rst)
    s_fire && key_event_next == EV_SINGLE |-> key_phase == PH_UP && click_pending)
    else $error("single click outside the up phase or without a pending click");

endmodule

>>> dv/key_click_double_long_detector_core_test.sv
// Stream testbench for the key click / double / long-press detector core.
`timescale 1ns / 100ps

module key_click_double_long_detector_core_test;
  import kcdl_pkg::*;

  localparam logic [IDX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int PHASE_TICKS = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;   // [0] key_level, [7:1] zero
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;          // [1:0] key_event, [7:2] zero
  logic cfg_we = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  key_click_double_long_detector_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // detector shadow state
  cfg_word_t scan_cfg, long_cfg, gap_cfg;
  phase_t key_ph;
  timer_t scan_cnt, hold_cnt, gap_cnt;
  logic click_armed;

  logic tick_q[$];
  event_t event_q[$];
  int ticks_queued = 0;
  int events_seen = 0;
  int fails = 0;
  logic calm = 1'b0;
  logic squeeze_req = 1'b0;
  logic squeezed = 1'b0;
  int hold_left = 0;
  int quiet = 0;
  event_t want_ev;

  function automatic timer_t bump(input timer_t v);
    return (v == '1) ? v : v + timer_t'(1);
  endfunction

  function automatic event_t next_key_event(input logic released);
    event_t ev;
    ev = EV_NONE;
    scan_cnt = bump(scan_cnt);
    hold_cnt = bump(hold_cnt);
    gap_cnt = bump(gap_cnt);
    if (scan_cnt >= scan_cfg) begin
      case (key_ph)
        PH_UP: begin
          if (!released) begin
            key_ph = PH_PRESS_BOUNCE;
          end else if (click_armed && gap_cnt >= gap_cfg) begin
            ev = EV_SINGLE;
            click_armed = 1'b0;
          end
        end
        PH_PRESS_BOUNCE: begin
          if (!released) begin
            key_ph = PH_DOWN;
            hold_cnt = '0;
          end else begin
            key_ph = PH_UP;
          end
        end
        PH_DOWN: begin
          if (!released) begin
            if (hold_cnt >= long_cfg) begin
              key_ph = PH_RELEASE_BOUNCE;
              ev = EV_LONG;
              click_armed = 1'b0;
            end
          end else begin
            key_ph = PH_RELEASE_BOUNCE;
            if (click_armed) begin
              ev = EV_DOUBLE;
              click_armed = 1'b0;
            end else begin
              click_armed = 1'b1;
              gap_cnt = '0;
            end
          end
        end
        default: begin
          if (released) key_ph = PH_UP;
        end
      endcase
      scan_cnt = '0;
    end
    return ev;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (fails < 50) $display("mismatch: %s", msg);
    fails++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) event_q.push_back(next_key_event(s_tdata[0]));
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, tick_q.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeezed) begin
      squeezed <= 1'b1;
      hold_left <= SQUEEZE_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (event_q.size() == 0) begin
        flag_mismatch($sformatf("event %0d with nothing pending", m_tdata[1:0]));
      end else begin
        want_ev = event_q.pop_front();
        if (m_tdata[1:0] != want_ev)
          flag_mismatch($sformatf("item %0d: key_event %0d, want %0d",
                                  events_seen, m_tdata[1:0], want_ev));
      end
      events_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic add_run(input logic level, input int n);
    repeat (n) begin
      tick_q.push_back(level);
      ticks_queued++;
    end
  endtask

  task automatic settle();
    while (events_seen < ticks_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_reg(input logic [IDX_WIDTH-1:0] idx, input cfg_word_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SCAN_PERIOD: scan_cfg = val;
      REG_LONG_PRESS:  long_cfg = val;
      REG_DOUBLE_GAP:  gap_cfg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input cfg_word_t p, input cfg_word_t l, input cfg_word_t g);
    load_reg(REG_SCAN_PERIOD, p);
    load_reg(REG_LONG_PRESS, l);
    load_reg(REG_DOUBLE_GAP, g);
    cfg_we <= 1'b0;
  endtask

  task automatic add_gesture(input int p, input int l, input int g);
    int kind;
    kind = $urandom_range(9);
    if ($urandom_range(9) < 3)
      repeat ($urandom_range(1, 4)) add_run(1'($urandom_range(1)), $urandom_range(1, p));
    case (kind)
      0, 1, 2: begin
        add_run(1'b0, $urandom_range(2 * p + 1, 2 * p + l));
        add_run(1'b1, $urandom_range(p + g, 3 * p + 2 * g));
      end
      3, 4: begin
        add_run(1'b0, $urandom_range(2 * p + 1, 2 * p + l));
        add_run(1'b1, $urandom_range(2 * p, 2 * p + g));
        add_run(1'b0, $urandom_range(2 * p + 1, 2 * p + l));
        add_run(1'b1, $urandom_range(p + g, 3 * p + 2 * g));
      end
      5, 6: begin
        add_run(1'b0, $urandom_range(l + 2 * p, l + 4 * p + 5));
        add_run(1'b1, $urandom_range(2 * p, 2 * p + g));
      end
      7: repeat ($urandom_range(1, 6)) add_run(1'($urandom_range(1)), $urandom_range(1, p + 1));
      8: repeat ($urandom_range(1, 12)) add_run(1'($urandom_range(1)), 1);
      default: add_run(1'b1, $urandom_range(1, 3 * p + g));
    endcase
  endtask

  task automatic random_phase(input cfg_word_t p, input cfg_word_t l, input cfg_word_t g,
                              input int count);
    int start;
    int lc;
    int gc;
    set_regs(p, l, g);
    lc = (int'(l) > 60) ? 60 : int'(l);
    gc = (int'(g) > 60) ? 60 : int'(g);
    start = ticks_queued;
    while (ticks_queued - start < count) add_gesture(int'(p), lc, gc);
    settle();
  endtask

  initial begin
    scan_cfg = SCAN_PERIOD_RESET;
    long_cfg = LONG_PRESS_RESET;
    gap_cfg = DOUBLE_GAP_RESET;
    key_ph = PH_UP;
    scan_cnt = '0;
    hold_cnt = '0;
    gap_cnt = '0;
    click_armed = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values
    add_run(1'b0, 3);
    add_run(1'b1, 3);
    settle();

    // zero scan period, zero long-press time, zero gap time
    set_regs(16'd0, 16'd0, 16'd0);
    add_run(1'b0, 3);
    add_run(1'b1, 2);
    add_run(1'b0, 2);
    add_run(1'b1, 3);
    settle();

    // double click, then a long press dropping a pending click; unused index ignored
    load_reg(REG_UNUSED, 16'hBEEF);
    set_regs(16'd1, 16'd3, 16'd5);
    add_run(1'b0, 2);
    add_run(1'b1, 2);
    add_run(1'b0, 2);
    add_run(1'b1, 3);
    add_run(1'b0, 2);
    add_run(1'b1, 2);
    add_run(1'b0, 6);
    add_run(1'b1, 7);
    settle();

    // all-ones registers: the machine never scans
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (10) add_run(1'($urandom_range(1)), 1);
    settle();

    // long hold right after a click with a wide gap time
    set_regs(16'd1, 16'd100, 16'hFFFF);
    add_run(1'b0, 2);
    add_run(1'b1, 1);
    add_run(1'b0, 120);
    add_run(1'b1, 3);
    settle();

    random_phase(cfg_word_t'($urandom_range(1, 4)), cfg_word_t'($urandom_range(4, 40)),
                 cfg_word_t'($urandom_range(4, 40)), PHASE_TICKS);
    calm = 1'b1;
    random_phase(cfg_word_t'($urandom_range(1, 4)), cfg_word_t'($urandom_range(4, 40)),
                 cfg_word_t'($urandom_range(4, 40)), PHASE_TICKS);
    calm = 1'b0;
    squeeze_req = 1'b1;
    random_phase(cfg_word_t'($urandom_range(1, 4)), cfg_word_t'($urandom_range(4, 40)),
                 cfg_word_t'($urandom_range(4, 40)), PHASE_TICKS);
    random_phase(16'd1, 16'd1, 16'd1, PHASE_TICKS);
    random_phase(16'd4, 16'hFFFF, 16'd20, PHASE_TICKS);
    random_phase(cfg_word_t'($urandom_range(1, 4)), cfg_word_t'($urandom_range(4, 40)),
                 cfg_word_t'($urandom_range(4, 40)), PHASE_TICKS);

    repeat (8) @(posedge clk);
    if (event_q.size() != 0) flag_mismatch($sformatf("%0d events never came", event_q.size()));
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
